FILE: rtl/sdmd_pkg.sv
package sdmd_pkg;

  localparam int unsigned PIX_W         = 8;
  localparam int unsigned IDX_W         = 16;
  localparam int unsigned AMP_W         = 4;
  localparam int unsigned VAR_W         = 8;
  localparam int unsigned TGT_W         = AMP_W + PIX_W;
  localparam int unsigned PIXEL_COUNT_DEF = 65536;

  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 4;

  localparam logic [AMP_W-1:0] AMP_RST  = 4'd2;
  localparam logic [VAR_W-1:0] VMIN_RST = 8'd1;
  localparam logic [VAR_W-1:0] VMAX_RST = 8'd254;

  typedef enum logic [1:0] {
    REG_AMPLIFICATION = 2'd0,
    REG_VARIANCE_MIN  = 2'd1,
    REG_VARIANCE_MAX  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [AMP_W-1:0] amplification;
    logic [VAR_W-1:0] variance_min;
    logic [VAR_W-1:0] variance_max;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] mean;
    logic [VAR_W-1:0] variance;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  function automatic logic [VAR_W-1:0] clamp_var(logic [VAR_W-1:0] v, cfg_t cfg);
    logic [VAR_W-1:0] r;
    r = v;
    if (r > cfg.variance_max) r = cfg.variance_max;
    if (r < cfg.variance_min) r = cfg.variance_min;
    return r;
  endfunction

endpackage

FILE: rtl/sdmd_if.sv
interface sdmd_pix_if import sdmd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic [IDX_W-1:0] pixel_index;
  logic             first_frame;

  modport source (output valid, pixel, pixel_index, first_frame, input ready);
  modport sink   (input valid, pixel, pixel_index, first_frame, output ready);
endinterface

interface sdmd_res_if import sdmd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             motion;
  logic [PIX_W-1:0] difference;
  logic [IDX_W-1:0] out_index;

  modport source (output valid, motion, difference, out_index, input ready);
  modport sink   (input valid, motion, difference, out_index, output ready);
endinterface

FILE: rtl/sdmd_cfg_regs.sv
module sdmd_cfg_regs import sdmd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_AMPLIFICATION: cfg_d.amplification = pwdata[AMP_W-1:0];
        REG_VARIANCE_MIN:  cfg_d.variance_min  = pwdata[VAR_W-1:0];
        REG_VARIANCE_MAX:  cfg_d.variance_max  = pwdata[VAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_AMPLIFICATION: prdata = APB_DW'(cfg_q.amplification);
      REG_VARIANCE_MIN:  prdata = APB_DW'(cfg_q.variance_min);
      REG_VARIANCE_MAX:  prdata = APB_DW'(cfg_q.variance_max);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.amplification <= AMP_RST;
      cfg_q.variance_min  <= VMIN_RST;
      cfg_q.variance_max  <= VMAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/sdmd_addr_map.sv
// Index to store address: index mod PixelCount via reciprocal multiply.
// Quotient estimate is registered; remainder and one correction follow.
module sdmd_addr_map import sdmd_pkg::*; #(
  parameter int unsigned PixelCount = PIXEL_COUNT_DEF,
  parameter int unsigned AddrW      = 16
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [IDX_W-1:0] idx_i,      // index entering the stage
  input  logic [IDX_W-1:0] idx_held_i, // index held in the stage
  output logic [AddrW-1:0] addr_o
);

  // indexes never exceed 2**IDX_W - 1, so larger stores see the index as is
  localparam longint unsigned EffN   = (PixelCount > (1 << IDX_W)) ?
                                       longint'(1 << IDX_W) : longint'(PixelCount);
  localparam longint unsigned RecipM = (64'd1 << 32) / EffN;
  localparam int unsigned     PW     = IDX_W + 33;

  logic [PW-1:0]    prod;
  logic [IDX_W-1:0] q_q;
  logic [33:0]      rem0, rem1;

  assign prod = PW'(idx_i) * PW'(RecipM);

  always_ff @(posedge clk_i) begin
    if (en_i) q_q <= prod[IDX_W+31:32];
  end

  // estimate is at most one short, so remainder stays below 2*EffN
  assign rem0 = 34'(idx_held_i) - 34'(q_q) * 34'(EffN);
  assign rem1 = (rem0 >= 34'(EffN)) ? rem0 - 34'(EffN) : rem0;
  assign addr_o = rem1[AddrW-1:0];

endmodule

FILE: rtl/sdmd_state_mem.sv
module sdmd_state_mem import sdmd_pkg::*; #(
  parameter int unsigned Depth = PIXEL_COUNT_DEF,
  parameter int unsigned AddrW = 16
) (
  input  logic               clk_i,
  input  logic               re_i,
  input  logic [AddrW-1:0]   raddr_i,
  output logic [ENTRY_W-1:0] rdata_o,
  input  logic               we_i,
  input  logic [AddrW-1:0]   waddr_i,
  input  logic [ENTRY_W-1:0] wdata_i
);

  logic [ENTRY_W-1:0] mem [Depth];
  logic [ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // read-before-write on a same-address collision; caller forwards
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/sdmd_update.sv
module sdmd_update import sdmd_pkg::*; (
  input  cfg_t             cfg_i,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic             first_i,
  input  entry_t           old_i,
  output entry_t           new_o,
  output logic [PIX_W-1:0] diff_o,
  output logic             motion_o
);

  logic [PIX_W-1:0] m;
  logic [VAR_W-1:0] v;
  logic [PIX_W-1:0] diff;
  logic [TGT_W-1:0] target;

  always_comb begin
    m      = old_i.mean;
    v      = old_i.variance;
    diff   = '0;
    target = '0;
    if (first_i) begin
      m = pixel_i;
      v = clamp_var(cfg_i.variance_min, cfg_i);
    end else begin
      if (m < pixel_i)      m = m + 1'b1;
      else if (m > pixel_i) m = m - 1'b1;
      diff   = (m > pixel_i) ? m - pixel_i : pixel_i - m;
      target = TGT_W'(cfg_i.amplification) * TGT_W'(diff);
      if (TGT_W'(v) < target) begin
        if (v != '1) v = v + 1'b1;
      end else if (TGT_W'(v) > target) begin
        v = v - 1'b1;
      end
      v = clamp_var(v, cfg_i);
    end
  end

  assign new_o.mean     = m;
  assign new_o.variance = v;
  assign diff_o         = diff;
  assign motion_o       = (diff >= v);

endmodule

FILE: rtl/sigma_delta_motion_detect_top.sv
// Channel   Dir  Payload                               Handshake
// pix_i     in   pixel, pixel_index, first_frame       valid/ready
// res_o     out  motion, difference, out_index         valid/ready
// apb       in   amplification, variance_min/max       psel/penable, pready=1
//
// One pixel per clock sustained while the output is not stalled.
// Stages: address map (registered quotient), memory read, update + write back
// into the output register. Back-to-back hits on one entry are forwarded.
// Reset clears valids and config only; the state memory holds garbage until
// a first-frame pixel writes each entry. A stalled output holds all stages.
module sigma_delta_motion_detect_top import sdmd_pkg::*; #(
  parameter int unsigned PixelCount = PIXEL_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sdmd_pix_if.sink          pix_i,
  sdmd_res_if.source        res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned AddrW = (PixelCount > 1) ? $clog2(PixelCount) : 1;

  cfg_t cfg;

  // address stage
  logic             p_vld_q;
  logic [PIX_W-1:0] p_pix_q;
  logic [IDX_W-1:0] p_idx_q;
  logic             p_first_q;
  logic [AddrW-1:0] p_addr;
  // read stage
  logic             s1_vld_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic             s1_first_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             fwd_hit_q;
  entry_t           fwd_data_q;
  // output stage
  logic             out_vld_q;
  logic             out_motion_q;
  logic [PIX_W-1:0] out_diff_q;
  logic [IDX_W-1:0] out_idx_q;

  logic             in_xfer, p_adv, s1_adv;
  logic [ENTRY_W-1:0] rdata;
  entry_t           old_entry, new_entry;
  logic [PIX_W-1:0] diff;
  logic             motion;

  sdmd_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  assign s1_adv      = s1_vld_q & (~out_vld_q | res_o.ready);
  assign p_adv       = p_vld_q & (~s1_vld_q | s1_adv);
  assign pix_i.ready = ~p_vld_q | p_adv;
  assign in_xfer     = pix_i.valid & pix_i.ready;

  sdmd_addr_map #(.PixelCount(PixelCount), .AddrW(AddrW)) u_addr (
    .clk_i,
    .en_i      (in_xfer),
    .idx_i     (pix_i.pixel_index),
    .idx_held_i(p_idx_q),
    .addr_o    (p_addr)
  );

  sdmd_state_mem #(.Depth(PixelCount), .AddrW(AddrW)) u_mem (
    .clk_i,
    .re_i   (p_adv),
    .raddr_i(p_addr),
    .rdata_o(rdata),
    .we_i   (s1_adv),
    .waddr_i(s1_addr_q),
    .wdata_i(new_entry)
  );

  assign old_entry = fwd_hit_q ? fwd_data_q : entry_t'(rdata);

  sdmd_update u_upd (
    .cfg_i   (cfg),
    .pixel_i (s1_pix_q),
    .first_i (s1_first_q),
    .old_i   (old_entry),
    .new_o   (new_entry),
    .diff_o  (diff),
    .motion_o(motion)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q   <= 1'b0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (pix_i.ready)               p_vld_q   <= pix_i.valid;
      if (~s1_vld_q | s1_adv)        s1_vld_q  <= p_vld_q;
      if (~out_vld_q | res_o.ready)  out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      p_pix_q   <= pix_i.pixel;
      p_idx_q   <= pix_i.pixel_index;
      p_first_q <= pix_i.first_frame;
    end
    if (p_adv) begin
      s1_pix_q   <= p_pix_q;
      s1_idx_q   <= p_idx_q;
      s1_first_q <= p_first_q;
      s1_addr_q  <= p_addr;
      // the write landing on this same edge is missed by the memory read
      fwd_hit_q  <= s1_adv & (s1_addr_q == p_addr);
      fwd_data_q <= new_entry;
    end
    if (s1_adv) begin
      out_motion_q <= motion;
      out_diff_q   <= diff;
      out_idx_q    <= s1_idx_q;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.motion     = out_motion_q;
  assign res_o.difference = out_diff_q;
  assign res_o.out_index  = out_idx_q;

endmodule
